@@ hw/rtl/pfe_pkg.sv @@
`default_nettype none
package pfe_pkg;
  // sizes fixed to the 4-bit key fields and 2-bit priority field
  localparam int NUM_STATES = 16;
  localparam int NUM_EVENTS = 16;
  localparam int NUM_PRIOS = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_SET = 3'd2;
  localparam logic [2:0] OP_ENQ = 3'd3;
  localparam logic [2:0] OP_DEQ = 3'd4;
  localparam logic [2:0] OP_PROC = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EXISTS = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADPRIO = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request fields, run first step and queue read
    logic lookup;   // second step: transition table read
    logic finish;   // third step: fire and load result
  } pfe_cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/pfe_ctrl.sv @@
`default_nettype none
module pfe_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  output pfe_pkg::pfe_cmd_t cmd
);
  import pfe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0] state;
  logic       take;

  // accept when no request is in flight and the result slot is free or leaving
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;
  assign cmd.capture = take;
  assign cmd.lookup = (state == S_LOOK);
  assign cmd.finish = (state == S_FIN);

  // advance the three-step sequence and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (take) state <= S_LOOK;
        S_LOOK: state <= S_FIN;
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (state == S_FIN) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/pfe_dp.sv @@
`default_nettype none
module pfe_dp (
  input  wire               clk,
  input  wire               rst,
  input  pfe_pkg::pfe_cmd_t cmd,
  input  wire  [2:0]        opcode,
  input  wire  [3:0]        state_key,
  input  wire  [3:0]        event_key,
  input  wire  [3:0]        next_state,
  input  wire               has_target,
  input  wire  [1:0]        priority_req,
  output logic [2:0]        status,
  output logic [3:0]        current_state,
  output logic              current_valid,
  output logic [6:0]        queued_total,
  output logic [3:0]        handled_event,
  output logic              moved
);
  import pfe_pkg::*;

  // state registry, one valid bit per state
  logic [NUM_STATES-1:0]            present;
  // transition table and its valid bits (cleared at reset)
  logic [NUM_STATES*NUM_EVENTS-1:0] tr_valid;
  logic [3:0]                       tr_mem [NUM_STATES*NUM_EVENTS];
  logic [3:0]                       q_mem [NUM_PRIOS*QUEUE_DEPTH];
  logic [3:0]                       head [NUM_PRIOS];
  logic [4:0]                       fill [NUM_PRIOS];
  logic [3:0]                       act;
  logic                             act_v;

  // latched request and read data of each step
  logic [2:0] r_op;
  logic [3:0] r_ek;
  logic       r_empty;
  logic [3:0] q_rd;
  logic [3:0] ev_r;
  logic       tv_rd;
  logic [3:0] tr_rd;

  // dequeue selection on the current fill counts
  logic       any;
  logic [1:0] sel;
  always_comb begin
    any = 1'b0;
    sel = '0;
    for (int p = 0; p < NUM_PRIOS; p++) begin
      if (fill[p] != '0) begin
        any = 1'b1;
        sel = 2'(p);
      end
    end
  end

  logic       full;
  logic [3:0] slot;
  logic [5:0] enq_addr, deq_addr;
  assign full = fill[priority_req][4];
  assign slot = head[priority_req] + fill[priority_req][3:0];
  assign enq_addr = {priority_req, slot};
  assign deq_addr = {sel, head[sel]};

  // event to fire: dequeued one or the request's own
  logic [3:0] fire_ev;
  logic [7:0] tr_addr;
  assign fire_ev = (r_op == OP_DEQ) ? q_rd : r_ek;
  assign tr_addr = {act, fire_ev};

  // fire decision on the registered table entry
  logic fire_hit;
  assign fire_hit = act_v && tv_rd && present[tr_rd];

  logic [6:0] tot;
  always_comb begin
    tot = '0;
    for (int p = 0; p < NUM_PRIOS; p++) tot = tot + 7'(fill[p]);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.capture && opcode == OP_ENQ && !full)
      q_mem[enq_addr] <= event_key;
    q_rd <= q_mem[deq_addr];
    if (cmd.capture && opcode == OP_LOAD)
      tr_mem[{state_key, event_key}] <= next_state;
    if (cmd.lookup) begin
      tr_rd <= tr_mem[tr_addr];
      tv_rd <= tr_valid[tr_addr];
      ev_r <= fire_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_op <= opcode;
      r_ek <= event_key;
      r_empty <= !any;
    end
    if (rst) begin
      present <= '0;
      tr_valid <= '0;
      act <= '0;
      act_v <= 1'b0;
      for (int p = 0; p < NUM_PRIOS; p++) begin
        head[p] <= '0;
        fill[p] <= '0;
      end
    end else if (cmd.capture) begin
      // table and queue updates of step one
      case (opcode)
        OP_ADD: begin
          if (present[state_key]) status <= ST_EXISTS;
          else begin
            status <= ST_OK;
            present[state_key] <= 1'b1;
          end
        end
        OP_LOAD: begin
          status <= ST_OK;
          tr_valid[{state_key, event_key}] <= has_target;
        end
        OP_SET: begin
          if (!present[state_key]) status <= ST_NOTFOUND;
          else begin
            status <= ST_OK;
            act <= state_key;
            act_v <= 1'b1;
          end
        end
        OP_ENQ: begin
          if (full) status <= ST_FULL;
          else begin
            status <= ST_OK;
            fill[priority_req] <= fill[priority_req] + 5'd1;
          end
        end
        OP_DEQ: begin
          status <= ST_OK;
          if (any) begin
            head[sel] <= head[sel] + 4'd1;
            fill[sel] <= fill[sel] - 5'd1;
          end
        end
        default: status <= ST_OK;
      endcase
    end else if (cmd.finish) begin
      // fire and load the result
      if (r_op == OP_PROC || (r_op == OP_DEQ && !r_empty)) begin
        handled_event <= ev_r;
        status <= fire_hit ? ST_OK : ST_NOTFOUND;
        moved <= fire_hit;
        if (fire_hit) act <= tr_rd;
      end else begin
        handled_event <= '0;
        moved <= 1'b0;
        if (r_op == OP_DEQ) status <= ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) queued_total <= tot;
  end

  assign current_state = act;
  assign current_valid = act_v;
endmodule
`default_nettype wire

@@ hw/rtl/prioritized_event_fsm_engine.sv @@
`default_nettype none
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | opcode state_key event_key next_state has_target priority_req
// output  | out_valid | out_stall | status current_state current_valid queued_total
//         |           |           | handled_event moved
// Each request runs as a queue read, the dependent transition read, then the fire.
// A new request is not taken until the previous one has fired and its result is taken or leaving.
// Reset clears the state registry, transition valid bits and queue counters at once.
// A held result stalls input until taken.
module prioritized_event_fsm_engine (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [2:0] opcode,
  input  wire  [3:0] state_key,
  input  wire  [3:0] event_key,
  input  wire  [3:0] next_state,
  input  wire        has_target,
  input  wire  [1:0] priority_req,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] status,
  output logic [3:0] current_state,
  output logic       current_valid,
  output logic [6:0] queued_total,
  output logic [3:0] handled_event,
  output logic       moved
);
  import pfe_pkg::*;

  pfe_cmd_t cmd;

  pfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  pfe_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .opcode(opcode), .state_key(state_key),
    .event_key(event_key), .next_state(next_state), .has_target(has_target),
    .priority_req(priority_req), .status(status), .current_state(current_state),
    .current_valid(current_valid), .queued_total(queued_total),
    .handled_event(handled_event), .moved(moved)
  );
endmodule
`default_nettype wire

@@ verif/pfe_scoreboard.sv @@
module pfe_scoreboard (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  input  wire       in_stall,
  input  wire [2:0] opcode,
  input  wire [3:0] state_key,
  input  wire [3:0] event_key,
  input  wire [3:0] next_state,
  input  wire       has_target,
  input  wire [1:0] priority_req,
  input  wire       out_valid,
  input  wire       out_stall,
  input  wire [2:0] status,
  input  wire [3:0] current_state,
  input  wire       current_valid,
  input  wire [6:0] queued_total,
  input  wire [3:0] handled_event,
  input  wire       moved,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfe_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] cur;
    logic       cur_ok;
    logic [6:0] total;
    logic [3:0] handled;
    logic       moved;
  } fsm_result_t;

  // engine model
  logic        registered [16];
  logic        tr_ok [256];
  logic [3:0]  tr_dst [256];
  logic [3:0]  ev_q [4][16];
  logic [3:0]  q_head [4];
  logic [4:0]  q_fill [4];
  logic [3:0]  cur_state;
  logic        cur_set;
  fsm_result_t expected_results [$];

  initial pending = 0;

  // try the transition for an event from the current state
  function automatic logic [2:0] take_event(input logic [3:0] ev, output logic mv);
    logic [7:0] idx;
    mv = 1'b0;
    if (!cur_set) return ST_NOTFOUND;
    idx = {cur_state, ev};
    if (!tr_ok[idx] || !registered[tr_dst[idx]]) return ST_NOTFOUND;
    cur_state = tr_dst[idx];
    mv = 1'b1;
    return ST_OK;
  endfunction

  function automatic fsm_result_t apply_request(input logic [2:0] op, input logic [3:0] sk,
      input logic [3:0] ek, input logic [3:0] ns, input logic ht, input logic [1:0] pr);
    fsm_result_t r;
    logic mv;
    int p;
    r = '0;
    mv = 1'b0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (registered[sk]) r.status = ST_EXISTS;
        else registered[sk] = 1'b1;
      end
      OP_LOAD: begin
        tr_ok[{sk, ek}] = ht;
        tr_dst[{sk, ek}] = ht ? ns : 4'd0;
      end
      OP_SET: begin
        if (!registered[sk]) r.status = ST_NOTFOUND;
        else begin
          cur_state = sk;
          cur_set = 1'b1;
        end
      end
      OP_ENQ: begin
        if (q_fill[pr] >= 16) r.status = ST_FULL;
        else begin
          ev_q[pr][4'(q_head[pr] + q_fill[pr])] = ek;
          q_fill[pr]++;
        end
      end
      OP_DEQ: begin
        r.status = ST_EMPTY;
        for (p = 3; p >= 0; p--) begin
          if (q_fill[p] != 0) begin
            r.handled = ev_q[p][q_head[p]];
            q_head[p] = q_head[p] + 4'd1;
            q_fill[p]--;
            r.status = take_event(r.handled, mv);
            break;
          end
        end
      end
      OP_PROC: begin
        r.handled = ek;
        r.status = take_event(ek, mv);
      end
      default: ;
    endcase
    r.moved = mv;
    r.cur = cur_state;
    r.cur_ok = cur_set;
    r.total = 7'(q_fill[0]) + 7'(q_fill[1]) + 7'(q_fill[2]) + 7'(q_fill[3]);
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    fsm_result_t got;
    fsm_result_t want;
    if (rst) begin
      for (int i = 0; i < 16; i++) registered[i] = 1'b0;
      for (int i = 0; i < 256; i++) begin
        tr_ok[i] = 1'b0;
        tr_dst[i] = 4'd0;
      end
      for (int i = 0; i < 4; i++) begin
        q_head[i] = 4'd0;
        q_fill[i] = 5'd0;
      end
      cur_state = 4'd0;
      cur_set = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, current_state, current_valid, queued_total, handled_event, moved};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp st=%0d cs=%0d cv=%0b qt=%0d ev=%0d mv=%0b",
                want.status, want.cur, want.cur_ok, want.total, want.handled, want.moved);
              $display("          got st=%0d cs=%0d cv=%0b qt=%0d ev=%0d mv=%0b",
                got.status, got.cur, got.cur_ok, got.total, got.handled, got.moved);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(opcode, state_key, event_key, next_state,
                                                 has_target, priority_req));
    end
    pending = expected_results.size();
  end
endmodule

@@ verif/prioritized_event_fsm_engine_test.sv @@
module prioritized_event_fsm_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pfe_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [3:0] state_key = '0;
  logic [3:0] event_key = '0;
  logic [3:0] next_state = '0;
  logic has_target = 1'b0;
  logic [1:0] priority_req = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] status;
  logic [3:0] current_state;
  logic current_valid;
  logic [6:0] queued_total;
  logic [3:0] handled_event;
  logic moved;
  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prioritized_event_fsm_engine dut (.*);
  pfe_scoreboard checker_i (.*);

  // drain results, stalling at random unless held off or calm
  always @(posedge clk) begin
    if (rst || hold_off) out_stall <= 1'b1;
    else out_stall <= !calm && ($urandom_range(99) < 23);
  end

  // hard limit on run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one request and wait for its acceptance
  task automatic send_request(input logic [2:0] op, input logic [3:0] sk, input logic [3:0] ek,
                              input logic [3:0] ns, input logic ht, input logic [1:0] pr);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    state_key <= sk;
    event_key <= ek;
    next_state <= ns;
    has_target <= ht;
    priority_req <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int weight_deq);
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 8) op = OP_ADD;
    else if (r < 28) op = OP_LOAD;
    else if (r < 36) op = OP_SET;
    else if (r < 60 - weight_deq) op = OP_ENQ;
    else if (r < 85) op = OP_DEQ;
    else if (r < 97) op = OP_PROC;
    else op = 3'($urandom_range(7, 6));
    send_request(op, 4'($urandom), 4'($urandom), 4'($urandom), 1'($urandom_range(9) != 0),
                 2'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: empty dequeue, no current state, registry, loads and fires
    send_request(OP_DEQ, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_PROC, 4'd0, 4'd15, 4'd0, 1'b0, 2'd0);
    send_request(OP_SET, 4'd3, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_ADD, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_ADD, 4'd15, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_ADD, 4'd15, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_LOAD, 4'd0, 4'd15, 4'd15, 1'b1, 2'd0);
    send_request(OP_LOAD, 4'd15, 4'd0, 4'd0, 1'b1, 2'd0);
    send_request(OP_LOAD, 4'd15, 4'd1, 4'd9, 1'b1, 2'd0);
    send_request(OP_LOAD, 4'd9, 4'd2, 4'd0, 1'b1, 2'd0);
    send_request(OP_SET, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_PROC, 4'd0, 4'd15, 4'd0, 1'b0, 2'd0);
    send_request(OP_PROC, 4'd0, 4'd1, 4'd0, 1'b0, 2'd0);
    send_request(OP_ENQ, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_ENQ, 4'd0, 4'd1, 4'd0, 1'b0, 2'd3);
    send_request(OP_DEQ, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_DEQ, 4'd0, 4'd0, 4'd0, 1'b0, 2'd0);
    send_request(OP_LOAD, 4'd0, 4'd15, 4'd15, 1'b0, 2'd0);
    send_request(OP_PROC, 4'd0, 4'd15, 4'd0, 1'b0, 2'd0);
    send_request(3'd6, 4'd5, 4'd5, 4'd5, 1'b1, 2'd1);
    send_request(3'd7, 4'd10, 4'd10, 4'd10, 1'b0, 2'd2);
    // fill one queue past full
    for (int i = 0; i < 17; i++) send_request(OP_ENQ, 4'd0, 4'(i), 4'd0, 1'b0, 2'd2);
    wait_idle();
    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_random(0);
    join
    wait_idle();
    // random traffic, alternating balanced and dequeue-heavy phases
    for (int i = 0; i < 1800; i++) begin
      calm = (i >= 600 && i < 800);
      send_random((i / 150) % 2 == 0 ? 0 : 12);
    end
    calm = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
